// ===== rtl/core/cbcs_pkg.sv =====
`timescale 1ns / 1ps

package cbcs_pkg;

    localparam int unsigned BLK_W = 128;
    localparam int unsigned CNT_W = 5;
    localparam int unsigned POS_W = 4;
    localparam int unsigned NROUNDS = 10;
    localparam logic [CNT_W-1:0] FULL_BYTES = 5'd16;
    localparam logic [POS_W-1:0] SKIP_RESET = 4'd9;

    localparam logic [2:0] REG_KEY_HI  = 3'd0;
    localparam logic [2:0] REG_KEY_LO  = 3'd1;
    localparam logic [2:0] REG_IV_HI   = 3'd2;
    localparam logic [2:0] REG_IV_LO   = 3'd3;
    localparam logic [2:0] REG_SKIP    = 3'd4;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [BLK_W-1:0] data;
        logic [CNT_W-1:0] bytes;
        logic             enc;
        logic             load_iv;
    } t_job;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block sits at bits [127-8i -: 8].
    function automatic logic [7:0] byte_at(input logic [BLK_W-1:0] s, input int i);
        return s[BLK_W-1-8*i -: 8];
    endfunction

    function automatic logic [BLK_W-1:0] next_key(input logic [BLK_W-1:0] k,
                                                   input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One round without key addition; mix selects MixColumns.
    function automatic logic [BLK_W-1:0] round_fn(input logic [BLK_W-1:0] s,
                                                   input logic mix);
        logic [7:0] m [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [BLK_W-1:0] o;
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                m[4*c+j] = sbox(byte_at(s, 4*((c+j)%4)+j));
        for (int c = 0; c < 4; c++) begin
            a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (mix) begin
                m[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                m[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                m[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                m[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            o[BLK_W-1-8*i -: 8] = m[i];
        return o;
    endfunction

endpackage

// ===== rtl/core/cbcs_front.sv =====
`timescale 1ns / 1ps

// Accepts items, tracks the pattern position, pushes classified jobs.
module cbcs_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [63:0]             i_data_high,
    input  logic [63:0]             i_data_low,
    input  logic [4:0]              i_valid_bytes,
    input  logic                    i_run_start,
    input  logic [3:0]              i_skip,
    output logic                    o_push,
    output cbcs_pkg::t_job          o_job,
    input  logic                    i_full
);
    import cbcs_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos, pos_eff;
    logic             full_blk, acc;

    assign o_stall  = i_full;
    assign acc      = i_valid && !i_full;
    assign o_push   = acc;
    assign full_blk = i_valid_bytes >= FULL_BYTES;
    assign pos_eff  = i_run_start ? '0 : r_pos;

    always_comb begin
        n_pos = r_pos;
        if (acc) begin
            n_pos = pos_eff;
            if (full_blk)
                n_pos = (pos_eff >= i_skip) ? '0 : pos_eff + 1'b1;
        end
    end

    assign o_job.data    = {i_data_high, i_data_low};
    assign o_job.bytes   = i_valid_bytes;
    assign o_job.enc     = full_blk && (pos_eff == '0);
    assign o_job.load_iv = i_run_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pos <= '0;
        else          r_pos <= n_pos;
    end

endmodule

// ===== rtl/core/cbcs_queue.sv =====
`timescale 1ns / 1ps

// Four-entry job queue between front and back.
module cbcs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cbcs_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_avail,
    output cbcs_pkg::t_job o_job,
    input  logic           i_pop
);
    import cbcs_pkg::*;

    t_job       r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_avail = r_cnt != 3'd0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_pop && !o_avail))
        else $error("queue underflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("queue count out of range");

endmodule

// ===== rtl/core/cbcs_back.sv =====
`timescale 1ns / 1ps

// Iterative AES-128 CBC core, one round a cycle while the output slot is free, with output register.
module cbcs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  cbcs_pkg::t_job i_job,
    output logic           o_pop,
    input  logic [127:0]   i_key,
    input  logic [127:0]   i_iv,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [127:0]   o_data,
    output logic [4:0]     o_bytes,
    output logic           o_enc
);
    import cbcs_pkg::*;

    typedef enum logic [1:0] {S_IDLE = 2'b01, S_RUN = 2'b10} t_state;

    t_state           r_st;
    logic [3:0]       r_rnd;
    logic [BLK_W-1:0] r_s, r_k, r_chain, chain_eff, nk, rs;
    logic [7:0]       rc;
    logic             r_ov, slot_free, take;

    assign slot_free = !r_ov || !i_stall;
    assign take      = (r_st == S_IDLE) && i_avail && slot_free;
    assign o_pop     = take;
    assign o_valid   = r_ov;
    assign chain_eff = i_job.load_iv ? i_iv : r_chain;

    always_comb begin
        unique case (r_rnd)
            4'd1: rc = 8'h01; 4'd2: rc = 8'h02; 4'd3: rc = 8'h04;
            4'd4: rc = 8'h08; 4'd5: rc = 8'h10; 4'd6: rc = 8'h20;
            4'd7: rc = 8'h40; 4'd8: rc = 8'h80; 4'd9: rc = 8'h1b;
            4'd10: rc = 8'h36;
            default: rc = 8'h00;
        endcase
    end
    assign nk = next_key(r_k, rc);
    assign rs = round_fn(r_s, r_rnd != 4'(NROUNDS)) ^ nk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_rnd <= '0; r_chain <= '0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (take) begin
                        if (i_job.load_iv) r_chain <= i_iv;
                        if (i_job.enc) begin
                            r_s   <= i_job.data ^ chain_eff ^ i_key;
                            r_k   <= i_key;
                            r_rnd <= 4'd1;
                            r_st  <= S_RUN;
                        end else begin
                            o_data  <= i_job.data;
                            r_ov    <= 1'b1;
                        end
                        o_bytes <= i_job.bytes;
                        o_enc   <= i_job.enc;
                    end
                end
                S_RUN: begin
                    r_s   <= rs;
                    r_k   <= nk;
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 4'(NROUNDS)) begin
                        // slot freed on entry to S_RUN was reserved for this item
                        if (!r_ov || !i_stall) begin
                            o_data  <= rs;
                            r_chain <= rs;
                            r_ov    <= 1'b1;
                            r_st    <= S_IDLE;
                        end else begin
                            r_s <= r_s; r_k <= r_k; r_rnd <= r_rnd;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_st))
        else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RUN) |-> (r_rnd >= 4'd1 && r_rnd <= 4'(NROUNDS)))
        else $error("round counter out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_pop |-> !(r_ov && i_stall))
        else $error("took item with output blocked");

endmodule

// ===== rtl/core/cbcs_pattern_aes_encryptor_unit.sv =====
`timescale 1ns / 1ps

// Channel  | dir | handshake       | payload
// input    | in  | valid / stall   | data_high, data_low, valid_bytes, run_start
// result   | out | valid / stall   | result_high, result_low, result_bytes, was_encrypted
// config   | in  | valid / ready   | cfg_index (0..4), cfg_data
//
// Encrypted block: in the back end a load, then ten rounds of the one shared
// round unit, the CBC chain feeding back from the last round. Clear or
// partial block: straight to the output register. The front end accepts
// an item a cycle into a four-entry queue; it stalls only when the queue is full.
// Reset is synchronous, active low; key and IV reset to zero, skip to nine.
// A stalled result holds in the output register; the back end takes a new
// item only once that register is free or emptying, then runs its rounds.
module cbcs_pattern_aes_encryptor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_run_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    output logic [4:0]  o_result_bytes,
    output logic        o_was_encrypted,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import cbcs_pkg::*;

    logic [63:0]      r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic [POS_W-1:0] r_skip;
    logic             push, full, avail, pop;
    t_job             fjob, bjob;
    logic [127:0]     res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0; r_key_lo <= '0; r_iv_hi <= '0; r_iv_lo <= '0;
            r_skip   <= SKIP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_HI: r_key_hi <= i_cfg_data;
                REG_KEY_LO: r_key_lo <= i_cfg_data;
                REG_IV_HI:  r_iv_hi  <= i_cfg_data;
                REG_IV_LO:  r_iv_lo  <= i_cfg_data;
                REG_SKIP:   r_skip   <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    cbcs_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_data_high, .i_data_low, .i_valid_bytes, .i_run_start,
        .i_skip(r_skip), .o_push(push), .o_job(fjob), .i_full(full)
    );

    cbcs_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(fjob), .o_full(full),
        .o_avail(avail), .o_job(bjob), .i_pop(pop)
    );

    cbcs_back u_back (
        .i_clk, .i_rst_n, .i_avail(avail), .i_job(bjob), .o_pop(pop),
        .i_key({r_key_hi, r_key_lo}), .i_iv({r_iv_hi, r_iv_lo}),
        .o_valid, .i_stall, .o_data(res), .o_bytes(o_result_bytes),
        .o_enc(o_was_encrypted)
    );

    assign o_result_high = res[127:64];
    assign o_result_low  = res[63:0];

endmodule
